// ----- rtl/ubr_pkg.sv -----
`default_nettype none

package ubr_pkg;

  // Serial framing
  localparam logic [7:0] MAGIC_BYTE = 8'h4E;
  localparam logic [7:0] PAD_BYTE   = 8'hFF;

  // Store byte index width (pairs of bytes, up to fourteen)
  localparam int unsigned IDX_W = 4;

  // Mode byte fields
  localparam logic [1:0] DIR_WRITE = 2'd1;
  localparam logic [1:0] DIR_READ  = 2'd2;
  localparam logic [1:0] DEV_XCVR  = 2'd1;
  localparam logic [1:0] DEV_CLK   = 2'd3;

  // Transceiver write requests carry the top address bit set
  localparam logic [7:0] XCVR_WR_FLAG = 8'h80;

  // Input word kinds
  localparam logic ACT_SERIAL = 1'b0;
  localparam logic ACT_RDATA  = 1'b1;

  // Result word kinds
  localparam logic KIND_TX  = 1'b0;
  localparam logic KIND_REQ = 1'b1;

  // Token codes between front and back
  typedef enum logic [1:0] {
    TOK_MODE,
    TOK_STORE,
    TOK_RDATA
  } tok_op_e;

  typedef struct packed {
    tok_op_e          op;
    logic             go;     // start execution once this token is applied
    logic [IDX_W-1:0] idx;    // store byte index
    logic [7:0]       value;
  } tok_t;

  // Back status seen by the front
  typedef struct packed {
    logic idle;
    logic waiting;
  } back_status_t;

  typedef enum logic [1:0] {
    F_HUNT,
    F_MODE,
    F_CMDS,
    F_EXEC
  } front_state_e;

  typedef enum logic [3:0] {
    B_IDLE,
    B_HEAD_N,
    B_HEAD_M,
    B_EX_FETCH,
    B_EXEC,
    B_WAIT,
    B_DP_FETCH,
    B_DP_ADDR,
    B_DP_DATA,
    B_PAD
  } back_state_e;

endpackage

`default_nettype wire

// ----- rtl/ubr_if.sv -----
`default_nettype none

// Input channel: received serial byte or returned read data
interface ubr_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] value;

  modport source (output valid, output action, output value, input ready);
  modport sink   (input valid, input action, input value, output ready);
endinterface

// Result channel: transmit byte or register access request
interface ubr_out_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] tx_byte;
  logic       req_device;
  logic       req_write;
  logic [7:0] req_address;
  logic [7:0] req_data;
  logic       last;

  modport source (output valid, output kind, output tx_byte, output req_device,
                  output req_write, output req_address, output req_data,
                  output last, input ready);
  modport sink   (input valid, input kind, input tx_byte, input req_device,
                  input req_write, input req_address, input req_data,
                  input last, output ready);
endinterface

`default_nettype wire

// ----- rtl/ubr_front.sv -----
`default_nettype none

module ubr_front #(
  parameter int unsigned MAX_COMMANDS = 7,
  parameter int unsigned CNT_W        = 3
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  ubr_in_if.sink                in_i,
  input  ubr_pkg::back_status_t status_i,
  input  wire                   q_ready_i,
  input  wire                   q_valid_i,
  output logic                  q_push_o,
  output ubr_pkg::tok_t         q_tok_o
);
  import ubr_pkg::*;

  front_state_e     state_q, state_d;
  logic [IDX_W-1:0] byte_idx_q, byte_idx_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  logic       ready;
  logic       accept;
  logic       serial;
  logic [3:0] mode_cnt;
  logic [7:0] mode_clamped;
  logic       pair_done;

  // Clamp the requested count
  always_comb begin
    mode_cnt = in_i.value[3:0];
    if (mode_cnt > 4'(MAX_COMMANDS)) begin
      mode_cnt = 4'(MAX_COMMANDS);
    end
    mode_clamped = {in_i.value[7:4], mode_cnt};
  end

  // While the back runs, input is taken only when it waits, and only read data is queued
  assign ready      = (state_q == F_EXEC) ? (status_i.waiting && !q_valid_i) : q_ready_i;
  assign in_i.ready = ready;
  assign accept     = in_i.valid && ready;
  assign serial     = (in_i.action == ACT_SERIAL);
  assign pair_done  = (IDX_W'(byte_idx_q + IDX_W'(1)) == IDX_W'({cnt_q, 1'b0}));

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      F_HUNT: begin
        if (accept && serial && in_i.value == MAGIC_BYTE) state_d = F_MODE;
      end
      F_MODE: begin
        if (accept && serial) state_d = (mode_cnt == 4'd0) ? F_EXEC : F_CMDS;
      end
      F_CMDS: begin
        if (accept && serial && pair_done) state_d = F_EXEC;
      end
      F_EXEC: begin
        if (status_i.idle && !q_valid_i) state_d = F_HUNT;
      end
      default: state_d = F_HUNT;
    endcase
  end

  // Token generation and counters
  always_comb begin
    q_push_o      = 1'b0;
    q_tok_o.op    = TOK_STORE;
    q_tok_o.go    = 1'b0;
    q_tok_o.idx   = byte_idx_q;
    q_tok_o.value = in_i.value;
    byte_idx_d    = byte_idx_q;
    cnt_d         = cnt_q;
    unique case (state_q)
      F_HUNT: ;
      F_MODE: begin
        if (accept && serial) begin
          q_push_o      = 1'b1;
          q_tok_o.op    = TOK_MODE;
          q_tok_o.go    = (mode_cnt == 4'd0);
          q_tok_o.value = mode_clamped;
          cnt_d         = CNT_W'(mode_cnt);
          byte_idx_d    = '0;
        end
      end
      F_CMDS: begin
        if (accept && serial) begin
          q_push_o   = 1'b1;
          q_tok_o.op = TOK_STORE;
          q_tok_o.go = pair_done;
          byte_idx_d = IDX_W'(byte_idx_q + IDX_W'(1));
        end
      end
      F_EXEC: begin
        if (accept && !serial) begin
          q_push_o   = 1'b1;
          q_tok_o.op = TOK_RDATA;
        end
      end
      default: ;
    endcase
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= F_HUNT;
      byte_idx_q <= '0;
      cnt_q      <= '0;
    end else begin
      state_q    <= state_d;
      byte_idx_q <= byte_idx_d;
      cnt_q      <= cnt_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/ubr_queue.sv -----
`default_nettype none

module ubr_queue (
  input  wire            clk_i,
  input  wire            rst_ni,
  input  wire            push_i,
  input  ubr_pkg::tok_t  tok_i,
  output logic           ready_o,
  output logic           valid_o,
  output ubr_pkg::tok_t  tok_o,
  input  wire            pop_i
);
  import ubr_pkg::*;

  tok_t       slot_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       do_push, do_pop;

  assign ready_o = (count_q != 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign tok_o   = slot_q[rd_ptr_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  // Slot storage
  always_ff @(posedge clk_i) begin
    if (do_push) slot_q[wr_ptr_q] <= tok_i;
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (do_push) wr_ptr_q <= !wr_ptr_q;
      if (do_pop)  rd_ptr_q <= !rd_ptr_q;
      case ({do_push, do_pop})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/ubr_back.sv -----
`default_nettype none

module ubr_back #(
  parameter int unsigned MAX_COMMANDS   = 7,
  parameter int unsigned RESPONSE_BYTES = 16,
  parameter int unsigned CNT_W          = 3
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   tok_valid_i,
  input  ubr_pkg::tok_t         tok_i,
  output logic                  tok_ready_o,
  output ubr_pkg::back_status_t status_o,
  ubr_out_if.source             out_o
);
  import ubr_pkg::*;

  localparam int unsigned ROW_W = (MAX_COMMANDS > 1) ? $clog2(MAX_COMMANDS) : 1;
  localparam int unsigned TX_W  = $clog2(RESPONSE_BYTES + 1);

  back_state_e      state_q, state_d;
  logic [7:0]       mode_q, mode_d;
  logic [CNT_W-1:0] row_q, row_d;
  logic [TX_W-1:0]  tx_cnt_q, tx_cnt_d;
  logic [1:0][7:0]  rd_q;
  logic [1:0][7:0]  mem_q [MAX_COMMANDS];

  // Result register
  logic       out_valid_q;
  logic       kind_q, req_device_q, req_write_q, last_q;
  logic [7:0] tx_byte_q, req_address_q, req_data_q;

  logic       emit_ok, emit;
  logic       e_kind, e_req_write, e_last;
  logic [7:0] e_tx_byte, e_req_address, e_req_data;

  logic             mem_we;
  logic [1:0]       mem_be;
  logic [ROW_W-1:0] mem_row;
  logic [7:0]       mem_wdata;
  logic             rd_en;

  logic [CNT_W-1:0] cnt;
  logic [1:0]       dev, dir;
  logic             active, devbit, rd_skip, at_end, row_last, tx_final;
  logic             is_read_req, tok_go;
  logic [7:0]       rd_a, rd_d;

  // Mode decode and per-pair conditions
  assign cnt      = mode_q[CNT_W-1:0];
  assign dev      = mode_q[5:4];
  assign dir      = mode_q[7:6];
  assign active   = (dev == DEV_XCVR) || (dev == DEV_CLK);
  assign devbit   = (dev == DEV_CLK);
  assign rd_a     = rd_q[0];
  assign rd_d     = rd_q[1];
  assign rd_skip  = (dev == DEV_XCVR) && rd_a[7];
  assign is_read_req = active && (dir == DIR_READ) && !rd_skip;
  assign at_end   = (row_q == cnt);
  assign row_last = (row_q == CNT_W'(cnt - CNT_W'(1)));
  assign tx_final = (tx_cnt_q == TX_W'(RESPONSE_BYTES - 1));
  assign tok_go   = tok_i.go && (tok_i.op == TOK_MODE || tok_i.op == TOK_STORE);
  assign emit_ok  = !out_valid_q || out_o.ready;
  assign rd_en    = (row_q < cnt);

  assign status_o.idle    = (state_q == B_IDLE);
  assign status_o.waiting = (state_q == B_WAIT);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      B_IDLE:   if (tok_valid_i && tok_go) state_d = B_HEAD_N;
      B_HEAD_N: if (emit_ok) state_d = B_HEAD_M;
      B_HEAD_M: if (emit_ok) state_d = B_EX_FETCH;
      B_EX_FETCH: begin
        if (at_end) state_d = (cnt == '0) ? B_PAD : B_DP_FETCH;
        else        state_d = B_EXEC;
      end
      B_EXEC: begin
        if (is_read_req) begin
          if (emit_ok) state_d = B_WAIT;
        end else if (active && dir == DIR_WRITE) begin
          if (emit_ok) state_d = B_EX_FETCH;
        end else begin
          state_d = B_EX_FETCH;
        end
      end
      B_WAIT:     if (tok_valid_i && tok_i.op == TOK_RDATA) state_d = B_EX_FETCH;
      B_DP_FETCH: state_d = B_DP_ADDR;
      B_DP_ADDR:  if (emit_ok) state_d = B_DP_DATA;
      B_DP_DATA: begin
        if (emit_ok) begin
          if (tx_final)      state_d = B_IDLE;
          else if (row_last) state_d = B_PAD;
          else               state_d = B_DP_FETCH;
        end
      end
      B_PAD:   if (emit_ok && tx_final) state_d = B_IDLE;
      default: state_d = B_IDLE;
    endcase
  end

  // Datapath control: token pops, store writes, result words
  always_comb begin
    tok_ready_o   = 1'b0;
    mode_d        = mode_q;
    row_d         = row_q;
    tx_cnt_d      = tx_cnt_q;
    mem_we        = 1'b0;
    mem_be        = 2'b00;
    mem_row       = row_q[ROW_W-1:0];
    mem_wdata     = 8'h00;
    emit          = 1'b0;
    e_kind        = KIND_TX;
    e_tx_byte     = 8'h00;
    e_req_write   = 1'b0;
    e_req_address = 8'h00;
    e_req_data    = 8'h00;
    e_last        = 1'b0;
    unique case (state_q)
      B_IDLE: begin
        tok_ready_o = tok_valid_i;
        if (tok_valid_i) begin
          case (tok_i.op)
            TOK_MODE: mode_d = tok_i.value;
            TOK_STORE: begin
              mem_we    = 1'b1;
              mem_row   = tok_i.idx[ROW_W:1];
              mem_be    = tok_i.idx[0] ? 2'b10 : 2'b01;
              mem_wdata = tok_i.value;
            end
            default: ;
          endcase
          if (tok_go) begin
            row_d    = '0;
            tx_cnt_d = '0;
          end
        end
      end
      B_HEAD_N: begin
        emit      = emit_ok;
        e_tx_byte = MAGIC_BYTE;
        if (emit_ok) tx_cnt_d = TX_W'(tx_cnt_q + TX_W'(1));
      end
      B_HEAD_M: begin
        emit      = emit_ok;
        e_tx_byte = mode_q;
        if (emit_ok) tx_cnt_d = TX_W'(tx_cnt_q + TX_W'(1));
      end
      B_EX_FETCH: begin
        if (at_end) row_d = '0;
      end
      B_EXEC: begin
        if (is_read_req) begin
          // read request ends this input's results
          emit          = emit_ok;
          e_kind        = KIND_REQ;
          e_req_address = rd_a;
          e_last        = 1'b1;
        end else if (active && dir == DIR_WRITE) begin
          emit          = emit_ok;
          e_kind        = KIND_REQ;
          e_req_write   = 1'b1;
          e_req_address = devbit ? rd_a : (rd_a | XCVR_WR_FLAG);
          e_req_data    = rd_d;
          if (emit_ok) begin
            mem_we = 1'b1;
            mem_be = 2'b10;
            row_d  = CNT_W'(row_q + CNT_W'(1));
          end
        end else if (active && dir != DIR_READ) begin
          // bad direction clears the whole pair
          mem_we = 1'b1;
          mem_be = 2'b11;
          row_d  = CNT_W'(row_q + CNT_W'(1));
        end else begin
          row_d = CNT_W'(row_q + CNT_W'(1));
        end
      end
      B_WAIT: begin
        tok_ready_o = tok_valid_i;
        if (tok_valid_i && tok_i.op == TOK_RDATA) begin
          mem_we    = 1'b1;
          mem_be    = 2'b10;
          mem_wdata = tok_i.value;
          row_d     = CNT_W'(row_q + CNT_W'(1));
        end
      end
      B_DP_FETCH: ;
      B_DP_ADDR: begin
        emit      = emit_ok;
        e_tx_byte = rd_a;
        if (emit_ok) tx_cnt_d = TX_W'(tx_cnt_q + TX_W'(1));
      end
      B_DP_DATA: begin
        emit      = emit_ok;
        e_tx_byte = rd_d;
        e_last    = tx_final;
        if (emit_ok) begin
          tx_cnt_d = TX_W'(tx_cnt_q + TX_W'(1));
          row_d    = CNT_W'(row_q + CNT_W'(1));
        end
      end
      B_PAD: begin
        emit      = emit_ok;
        e_tx_byte = PAD_BYTE;
        e_last    = tx_final;
        if (emit_ok) tx_cnt_d = TX_W'(tx_cnt_q + TX_W'(1));
      end
      default: ;
    endcase
  end

  // Pair store, one row per pair, byte lane writes, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we && mem_be[0]) mem_q[mem_row][0] <= mem_wdata;
    if (mem_we && mem_be[1]) mem_q[mem_row][1] <= mem_wdata;
    if (rd_en) rd_q <= mem_q[row_q[ROW_W-1:0]];
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (emit) begin
      kind_q        <= e_kind;
      tx_byte_q     <= e_tx_byte;
      req_device_q  <= (e_kind == KIND_REQ) ? devbit : 1'b0;
      req_write_q   <= e_req_write;
      req_address_q <= e_req_address;
      req_data_q    <= e_req_data;
      last_q        <= e_last;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      mode_q      <= 8'h00;
      row_q       <= '0;
      tx_cnt_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      mode_q   <= mode_d;
      row_q    <= row_d;
      tx_cnt_q <= tx_cnt_d;
      if (emit)             out_valid_q <= 1'b1;
      else if (out_o.ready) out_valid_q <= 1'b0;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.kind        = kind_q;
  assign out_o.tx_byte     = tx_byte_q;
  assign out_o.req_device  = req_device_q;
  assign out_o.req_write   = req_write_q;
  assign out_o.req_address = req_address_q;
  assign out_o.req_data    = req_data_q;
  assign out_o.last        = last_q;

endmodule

`default_nettype wire

// ----- rtl/uart_register_access_bridge.sv -----
// Serial bytes are taken one per cycle while collecting a packet and the queue has
// room; a word reaches the executor through a two-entry token queue, which
// registers it. After a packet end, results follow at most one per cycle as the
// output takes them; an executed pair has fetch and execute states, an echoed one
// fetch (store read), address and data; a full packet gives 16 bytes, 7 requests.
// Reset clears all control state; the pair store is not cleared.
`default_nettype none

module uart_register_access_bridge #(
  parameter int unsigned MAX_COMMANDS   = 7,
  parameter int unsigned RESPONSE_BYTES = 16
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  ubr_in_if.sink     in_i,
  ubr_out_if.source  out_o
);
  import ubr_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_COMMANDS + 1);

  back_status_t status;
  tok_t         push_tok, pop_tok;
  logic         push, q_ready, q_valid, pop;

  // Packet parser
  ubr_front #(
    .MAX_COMMANDS (MAX_COMMANDS),
    .CNT_W        (CNT_W)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .status_i  (status),
    .q_ready_i (q_ready),
    .q_valid_i (q_valid),
    .q_push_o  (push),
    .q_tok_o   (push_tok)
  );

  // Token queue
  ubr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .tok_i   (push_tok),
    .ready_o (q_ready),
    .valid_o (q_valid),
    .tok_o   (pop_tok),
    .pop_i   (pop)
  );

  // Executor and response generator
  ubr_back #(
    .MAX_COMMANDS   (MAX_COMMANDS),
    .RESPONSE_BYTES (RESPONSE_BYTES),
    .CNT_W          (CNT_W)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tok_valid_i (q_valid),
    .tok_i       (pop_tok),
    .tok_ready_o (pop),
    .status_o    (status),
    .out_o       (out_o)
  );

endmodule

`default_nettype wire
